/* rtl/ttoi_pkg.sv */
// ttoi_pkg: shared types, register map and character constants for the
// text-to-integer core. No dependencies.
`timescale 1ns / 1ps

package ttoi_pkg;

    // digit alphabet storage
    localparam int SLOTS      = 32;
    localparam int MAX_DIGITS = 32;
    localparam int COUNT_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int VALUE_W    = 32;
    localparam int ALPHA_W    = 64;
    localparam int ALPHA_WORDS = 4;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;

    // character codes
    localparam logic [CHAR_W-1:0] CH_TAB_LO   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR_HI    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TILDE    = 8'd126;
    localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS     = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_NUL      = 8'd0;

    // register index, byte address bits [5:3]
    typedef enum logic [2:0] {
        REG_DIGIT_COUNT = 3'd0,
        REG_ALPHA_0     = 3'd1,
        REG_ALPHA_1     = 3'd2,
        REG_ALPHA_2     = 3'd3,
        REG_ALPHA_3     = 3'd4
    } reg_idx_t;

    // parse phase
    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return ((c >= CH_TAB_LO) && (c <= CH_CR_HI)) || (c == CH_SPACE);
    endfunction

    function automatic logic is_sign(input logic [CHAR_W-1:0] c);
        return (c == CH_MINUS) || (c == CH_PLUS);
    endfunction

endpackage

/* rtl/text_to_integer_any_base_core.sv */
// text_to_integer_any_base_core: streaming text to signed integer parser
// with a programmable digit alphabet. Depends on ttoi_pkg.
`timescale 1ns / 1ps

// One character enters per item and the core sustains one item per cycle
// while no last item is stalled. Each item goes from the input register
// through one pass of logic (a parallel compare against the 32 alphabet
// slots, a priority pick and one 32x6 multiply-add) into the parse state,
// so the next character can follow in the next cycle. The item marked last
// moves from the input register, once the output register has room, into
// the output register as one 32-bit result, where it waits to be taken.
// Characters keep flowing while a result waits; only a further last item
// stalls in the input register until the waiting result is taken. Leading
// whitespace is skipped, a run of '+'/'-' sets the sign, digits accumulate
// as acc * digit_count + position, and the first non-digit ends the number;
// results wrap to 32 bits. The alphabet check is evaluated every cycle into
// a registered valid flag, so it follows a configuration write in the next cycle;
// an invalid alphabet (fewer than two digits, more than the slots, signs,
// spaces, control or non-printable codes, or a repeated character) forces
// the result to 0. Registers sit at byte addresses 8*i on a 64-bit APB
// port: digit_count, then alphabet words 0 to 3.
module text_to_integer_any_base_core
    import ttoi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // character stream
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CHAR_W-1:0]   ch,
    input  logic                last,
    // result stream
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [VALUE_W-1:0] value,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]                     count_reg;
    logic [ALPHA_WORDS-1:0][ALPHA_W-1:0]    alpha_reg;
    logic [SLOTS-1:0][CHAR_W-1:0]           slots;
    logic                                   alpha_ok_reg;
    logic                                   alpha_ok_next;
    logic                                   cfg_wr;
    reg_idx_t                               cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign slots   = alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            alpha_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_DIGIT_COUNT: count_reg    <= pwdata[COUNT_W-1:0];
                REG_ALPHA_0:     alpha_reg[0] <= pwdata;
                REG_ALPHA_1:     alpha_reg[1] <= pwdata;
                REG_ALPHA_2:     alpha_reg[2] <= pwdata;
                REG_ALPHA_3:     alpha_reg[3] <= pwdata;
                default:         ;
            endcase
        end
    end

    // readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_DIGIT_COUNT: prdata = {{(DATA_W-COUNT_W){1'b0}}, count_reg};
            REG_ALPHA_0:     prdata = alpha_reg[0];
            REG_ALPHA_1:     prdata = alpha_reg[1];
            REG_ALPHA_2:     prdata = alpha_reg[2];
            REG_ALPHA_3:     prdata = alpha_reg[3];
            default:         prdata = '0;
        endcase
    end

    // alphabet check, registered in the cycle after any write; only the first
    // count slots take part, and a count above the slot range fails the check
    always_comb
    begin
        alpha_ok_next = (count_reg >= COUNT_W'(2))
                     && (count_reg <= COUNT_W'(MAX_DIGITS))
                     && (count_reg <= COUNT_W'(SLOTS));
        for (int i = 0; i < SLOTS; i++)
        begin
            if (COUNT_W'(i) < count_reg)
            begin
                if (is_sign(slots[i]) || (slots[i] <= CH_SPACE)
                    || (slots[i] > CH_TILDE))
                    alpha_ok_next = 1'b0;
                for (int j = i + 1; j < SLOTS; j++)
                begin
                    if ((COUNT_W'(j) < count_reg) && (slots[j] == slots[i]))
                        alpha_ok_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_ok_reg <= 1'b0;
        else
            alpha_ok_reg <= alpha_ok_next;
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic                in_valid_reg;
    logic [CHAR_W-1:0]   ch_reg;
    logic                last_reg;
    logic                step;          // held item is processed this cycle
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  value_reg;

    // a last item needs room in the output register, others never stall
    assign step     = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
    end

    // ------------------------------------------------------------------
    // digit lookup: first matching slot within the count
    // ------------------------------------------------------------------
    logic [SLOTS-1:0]    hit;
    logic                found;
    logic [COUNT_W-1:0]  pos;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
            hit[i] = (slots[i] == ch_reg) && (COUNT_W'(i) < count_reg);
        found = |hit;
        pos   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (hit[i])
                pos = COUNT_W'(i);
        end
        // slot past the registers reads as nul
        if (!found && (ch_reg == CH_NUL) && (count_reg > COUNT_W'(SLOTS)))
        begin
            found = 1'b1;
            pos   = COUNT_W'(SLOTS);
        end
    end

    // ------------------------------------------------------------------
    // parse state
    // ------------------------------------------------------------------
    phase_t              phase_reg, phase_next;
    logic                neg_reg, neg_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic [VALUE_W-1:0]  result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else if (step)
        begin
            if (last_reg)
            begin
                phase_reg <= PH_SKIP;
                neg_reg   <= 1'b0;
                acc_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if ((phase_reg == PH_SKIP) && is_space(ch_reg))
        begin
            // still in leading whitespace
        end
        else if ((phase_reg <= PH_SIGN) && is_sign(ch_reg))
        begin
            phase_next = PH_SIGN;
            if (ch_reg == CH_MINUS)
                neg_next = !neg_reg;
        end
        else if (phase_reg <= PH_DIGIT)
        begin
            if (found)
            begin
                phase_next = PH_DIGIT;
                acc_next   = acc_reg * VALUE_W'(count_reg) + VALUE_W'(pos);
            end
            else
                phase_next = PH_DONE;
        end
        // result from the state after this character
        if (!alpha_ok_reg)
            result = '0;
        else if (neg_next)
            result = '0 - acc_next;
        else
            result = acc_next;
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && last_reg)
            value_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign value     = $signed(value_reg);

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last_reg) |=> out_valid_reg)
        else $error("last item did not load a result");

    a_state_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last_reg) |=> (phase_reg == PH_SKIP) && !neg_reg && (acc_reg == '0))
        else $error("parse state not cleared after last item");

    a_bad_alphabet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last_reg && !alpha_ok_reg) |=> (value_reg == '0))
        else $error("invalid alphabet gave a nonzero result");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && last_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while last item is stalled");

endmodule
